// ===== hdl/pfra_pkg.sv =====
// shared types and constants of the page frame reference count allocator
`timescale 1ns / 1ps

package pfra_pkg;

  localparam int REG_W     = 13;
  localparam int PAGE_W    = 12;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 8;

  localparam logic [REG_W-1:0] RESET_TOTAL = 13'd4096;
  localparam logic [REG_W-1:0] RESET_FIRST = 13'h400;

  // register indexes on the configuration port
  localparam logic [0:0] REG_TOTAL = 1'b0;
  localparam logic [0:0] REG_FIRST = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_SHARE   = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WINDOW   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;  // write zero at the sweep pointer
    logic load;   // capture a new transaction
    logic read;   // read the count of the captured page
    logic exec;   // finish a page operation
    logic scan;   // one step of the first-fit search
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic alloc_req;   // op on the input ports is allocate
    logic scan_done;   // search found a frame or ran off the window
    logic clear_last;  // sweep pointer is at the last frame
  } sts_t;

endpackage

// ===== hdl/pfra_ctrl.sv =====
// controller state machine of the page frame reference count allocator
`timescale 1ns / 1ps

module pfra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pfra_pkg::sts_t sts,
  output pfra_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.alloc_req ? S_SCAN : S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_read_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> cmd.exec)
    else $error("count read not followed by execute");

endmodule

// ===== hdl/pfra_datapath.sv =====
// count store, window check, first-fit search and result registers
`timescale 1ns / 1ps

module pfra_datapath #(
  parameter int PAGE_FRAMES = 4096,
  parameter int COUNT_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pfra_pkg::cmd_t                    cmd,
  output pfra_pkg::sts_t                    sts,
  input  logic [pfra_pkg::OP_W-1:0]         op,
  input  logic [pfra_pkg::PAGE_W-1:0]       page_number,
  input  logic                              write_enable,
  input  logic [0:0]                        register_index,
  input  logic [pfra_pkg::REG_W-1:0]        write_data,
  output logic                              done,
  output logic [pfra_pkg::STATUS_W-1:0]     status,
  output logic [pfra_pkg::PAGE_W-1:0]       result_page,
  output logic [pfra_pkg::CNT_OUT_W-1:0]    ref_count,
  output logic                              copy_needed
);

  localparam int AW  = $clog2(PAGE_FRAMES);
  localparam int EW  = ($clog2(PAGE_FRAMES + 1) > pfra_pkg::REG_W) ?
                       $clog2(PAGE_FRAMES + 1) : pfra_pkg::REG_W;
  localparam int CW  = COUNT_BITS;
  localparam int OW  = pfra_pkg::CNT_OUT_W;
  localparam int PW  = pfra_pkg::PAGE_W;
  localparam logic [EW-1:0] FRAMES_E = EW'(PAGE_FRAMES);
  localparam logic [EW-1:0] LAST_E   = EW'(PAGE_FRAMES - 1);
  localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [pfra_pkg::REG_W-1:0] total_pages;
  logic [pfra_pkg::REG_W-1:0] first_usable_page;

  logic [pfra_pkg::OP_W-1:0] op_r;
  logic [PW-1:0]             page_r;
  logic [EW-1:0]             ptr;
  logic [EW-1:0]             chk_ptr;
  logic                      chk_valid;

  logic [CW-1:0] mem [PAGE_FRAMES];
  logic [CW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic          mem_we;

  logic [EW-1:0] total_e;
  logic [EW-1:0] first_e;
  logic [EW-1:0] win_end;
  logic [EW-1:0] page_e;
  logic          in_win;

  logic scan_found;
  logic scan_exhausted;
  logic scan_done;
  logic scan_issue;

  logic [pfra_pkg::STATUS_W-1:0] ex_status;
  logic [CW-1:0]                 ex_count;
  logic                          ex_copy;
  logic                          ex_we;
  logic [CW-1:0]                 ex_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages       <= pfra_pkg::RESET_TOTAL;
      first_usable_page <= pfra_pkg::RESET_FIRST;
    end else if (write_enable) begin
      case (register_index)
        pfra_pkg::REG_TOTAL: total_pages       <= write_data;
        pfra_pkg::REG_FIRST: first_usable_page <= write_data;
        default: ;
      endcase
    end
  end

  // usable window is first_usable_page up to min(total_pages, PAGE_FRAMES)
  assign total_e = EW'(total_pages);
  assign first_e = EW'(first_usable_page);
  assign win_end = (total_e > FRAMES_E) ? FRAMES_E : total_e;
  assign page_e  = EW'(page_r);
  assign in_win  = (page_e >= first_e) && (page_e < win_end);

  // first-fit search: read at ptr each cycle, test the word read in the previous cycle
  assign scan_found     = chk_valid && (rd_data == '0);
  assign scan_exhausted = !scan_found && (ptr >= win_end);
  assign scan_done      = scan_found || scan_exhausted;
  assign scan_issue     = cmd.scan && !scan_done;

  assign sts.alloc_req  = (op == pfra_pkg::OP_ALLOC);
  assign sts.scan_done  = scan_done;
  assign sts.clear_last = (ptr == LAST_E);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      chk_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr       <= first_e;
        chk_valid <= 1'b0;
      end else if (cmd.clear || scan_issue) begin
        ptr <= ptr + EW'(1);
      end
      if (cmd.scan) begin
        chk_valid <= scan_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      page_r <= page_number;
    end
    if (scan_issue) begin
      chk_ptr <= ptr;
    end
  end

  // page operation on the count read in the previous cycle
  always_comb begin
    ex_status = pfra_pkg::ST_OK;
    ex_count  = '0;
    ex_copy   = 1'b0;
    ex_we     = 1'b0;
    ex_wdata  = rd_data;
    if (!in_win) begin
      ex_status = pfra_pkg::ST_WINDOW;
    end else begin
      case (op_r)
        pfra_pkg::OP_FREE: begin
          if (rd_data == '0) begin
            ex_status = pfra_pkg::ST_NOTALLOC;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = rd_data - CNT_ONE;
            ex_count = rd_data - CNT_ONE;
          end
        end
        pfra_pkg::OP_SHARE: begin
          if (rd_data == '0) begin
            ex_status = pfra_pkg::ST_NOTALLOC;
          end else if (rd_data == CNT_MAX) begin
            ex_status = pfra_pkg::ST_SAT;
            ex_count  = rd_data;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = rd_data + CNT_ONE;
            ex_count = rd_data + CNT_ONE;
          end
        end
        pfra_pkg::OP_RELEASE: begin
          if (rd_data == '0) begin
            ex_status = pfra_pkg::ST_NOTALLOC;
          end else if (rd_data > CNT_ONE) begin
            ex_we    = 1'b1;
            ex_copy  = 1'b1;
            ex_wdata = rd_data - CNT_ONE;
            ex_count = rd_data - CNT_ONE;
          end else begin
            ex_count = rd_data;
          end
        end
        default: begin
          // query and unused codes
          ex_count = rd_data;
        end
      endcase
    end
  end

  // count store
  always_comb begin
    rd_addr = cmd.scan ? ptr[AW-1:0] : page_e[AW-1:0];
    if (cmd.clear) begin
      wr_addr = ptr[AW-1:0];
      wr_data = '0;
      mem_we  = 1'b1;
    end else if (cmd.scan) begin
      wr_addr = chk_ptr[AW-1:0];
      wr_data = CNT_ONE;
      mem_we  = scan_found;
    end else begin
      wr_addr = page_e[AW-1:0];
      wr_data = ex_wdata;
      mem_we  = cmd.exec && ex_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // result registers, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec || (cmd.scan && scan_done);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= ex_status;
      result_page <= page_r;
      ref_count   <= OW'(ex_count);
      copy_needed <= ex_copy;
    end else if (cmd.scan && scan_found) begin
      status      <= pfra_pkg::ST_OK;
      result_page <= PW'(chk_ptr);
      ref_count   <= OW'(CNT_ONE);
      copy_needed <= 1'b0;
    end else if (cmd.scan && scan_exhausted) begin
      status      <= pfra_pkg::ST_NOFREE;
      result_page <= '0;
      ref_count   <= '0;
      copy_needed <= 1'b0;
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec || cmd.scan))
    else $error("result strobe without a finishing step");

  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (done && copy_needed) |-> (status == pfra_pkg::ST_OK && $past(op_r) == pfra_pkg::OP_RELEASE))
    else $error("copy flag outside a successful release");

  a_nofree: assert property (@(posedge clk) disable iff (rst)
    (done && status == pfra_pkg::ST_NOFREE) |-> (result_page == '0 && ref_count == '0))
    else $error("no-free result carries a page or count");

endmodule

// ===== hdl/page_frame_refcount_allocator_unit.sv =====
// top level of the page frame reference count allocator
`timescale 1ns / 1ps

// After reset the count store is swept to zero one frame per cycle while busy
// stays high; configuration writes are taken during the sweep. A transaction
// is accepted when start is high and busy is low, and its single result
// appears on the result ports for one cycle with done high. Free, share,
// release and query pass through a count memory read state and then an update
// state before the next acceptance is possible. Allocate walks the memory one
// frame per cycle from first_usable_page until it finds a zero count or runs
// off the end of the window. Results cannot be held off: the receiver must
// take each one in the cycle it is shown.
module page_frame_refcount_allocator_unit #(
  parameter int PAGE_FRAMES = 4096,
  parameter int COUNT_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pfra_pkg::OP_W-1:0]         op,
  input  logic [pfra_pkg::PAGE_W-1:0]       page_number,
  output logic                              done,
  output logic [pfra_pkg::STATUS_W-1:0]     status,
  output logic [pfra_pkg::PAGE_W-1:0]       result_page,
  output logic [pfra_pkg::CNT_OUT_W-1:0]    ref_count,
  output logic                              copy_needed,
  input  logic                              write_enable,
  input  logic [0:0]                        register_index,
  input  logic [pfra_pkg::REG_W-1:0]        write_data
);

  pfra_pkg::cmd_t cmd;
  pfra_pkg::sts_t sts;

  pfra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pfra_datapath #(
    .PAGE_FRAMES (PAGE_FRAMES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (op),
    .page_number    (page_number),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .done           (done),
    .status         (status),
    .result_page    (result_page),
    .ref_count      (ref_count),
    .copy_needed    (copy_needed)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the page frame reference count allocator
`timescale 1ns / 1ps

module tb;

  localparam int FRAMES = 4096;
  localparam logic [pfra_pkg::CNT_OUT_W-1:0] COUNT_TOP = 8'hFF;
  // codes 5..7 have no meaning of their own and act as a query
  localparam logic [pfra_pkg::OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
  localparam int QUIET_LIMIT = 40000;

  typedef struct packed {
    logic [pfra_pkg::OP_W-1:0]   code;
    logic [pfra_pkg::PAGE_W-1:0] page;
  } page_cmd_t;

  typedef struct packed {
    logic [pfra_pkg::STATUS_W-1:0]  status;
    logic [pfra_pkg::PAGE_W-1:0]    result_page;
    logic [pfra_pkg::CNT_OUT_W-1:0] ref_count;
    logic                           copy_needed;
  } frame_result_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [pfra_pkg::OP_W-1:0] op = pfra_pkg::OP_QUERY;
  logic [pfra_pkg::PAGE_W-1:0] page_number = '0;
  logic write_enable = 1'b0;
  logic [0:0] register_index = pfra_pkg::REG_TOTAL;
  logic [pfra_pkg::REG_W-1:0] write_data = '0;
  logic busy;
  logic done;
  logic [pfra_pkg::STATUS_W-1:0] status;
  logic [pfra_pkg::PAGE_W-1:0] result_page;
  logic [pfra_pkg::CNT_OUT_W-1:0] ref_count;
  logic copy_needed;

  page_frame_refcount_allocator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .page_number(page_number), .done(done), .status(status),
    .result_page(result_page), .ref_count(ref_count), .copy_needed(copy_needed),
    .write_enable(write_enable), .register_index(register_index),
    .write_data(write_data)
  );

  // shadow of the allocator state
  logic [pfra_pkg::CNT_OUT_W-1:0] frame_refs [FRAMES];
  logic [pfra_pkg::REG_W-1:0] cfg_total = pfra_pkg::RESET_TOTAL;
  logic [pfra_pkg::REG_W-1:0] cfg_first = pfra_pkg::RESET_FIRST;

  page_cmd_t pending_cmds [$];
  frame_result_t expected_results [$];
  page_cmd_t next_cmd;
  frame_result_t predicted;
  frame_result_t want;
  bit steady_flow = 1'b0;
  int mismatches = 0;
  int issued = 0;
  int settings = 0;
  int copies = 0;
  int quiet = 0;
  int status_seen [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int win_end();
    return (cfg_total > FRAMES) ? FRAMES : int'(cfg_total);
  endfunction

  function automatic frame_result_t apply_frame_op(
    input logic [pfra_pkg::OP_W-1:0] code,
    input logic [pfra_pkg::PAGE_W-1:0] page);
    frame_result_t r;
    logic [pfra_pkg::CNT_OUT_W-1:0] c;
    int last;
    bit found;
    r.status = pfra_pkg::ST_OK;
    r.result_page = page;
    r.ref_count = '0;
    r.copy_needed = 1'b0;
    last = win_end();
    found = 1'b0;
    if (code == pfra_pkg::OP_ALLOC) begin
      r.result_page = '0;
      // first fit: lowest zero count in the window
      for (int p = int'(cfg_first); p < last && !found; p++) begin
        if (frame_refs[p] == 0) begin
          frame_refs[p] = 8'd1;
          r.result_page = p[pfra_pkg::PAGE_W-1:0];
          r.ref_count = 8'd1;
          found = 1'b1;
        end
      end
      if (!found) r.status = pfra_pkg::ST_NOFREE;
    end else if (int'(page) < int'(cfg_first) || int'(page) >= last) begin
      r.status = pfra_pkg::ST_WINDOW;
    end else begin
      c = frame_refs[page];
      case (code)
        pfra_pkg::OP_FREE: begin
          if (c == 0) r.status = pfra_pkg::ST_NOTALLOC;
          else begin
            frame_refs[page] = c - 8'd1;
            r.ref_count = c - 8'd1;
          end
        end
        pfra_pkg::OP_SHARE: begin
          if (c == 0) r.status = pfra_pkg::ST_NOTALLOC;
          else if (c == COUNT_TOP) begin
            r.status = pfra_pkg::ST_SAT;
            r.ref_count = c;
          end else begin
            frame_refs[page] = c + 8'd1;
            r.ref_count = c + 8'd1;
          end
        end
        pfra_pkg::OP_RELEASE: begin
          if (c == 0) r.status = pfra_pkg::ST_NOTALLOC;
          else if (c > 1) begin
            frame_refs[page] = c - 8'd1;
            r.ref_count = c - 8'd1;
            r.copy_needed = 1'b1;
          end else r.ref_count = c;
        end
        default: r.ref_count = c;
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // driver: one transaction at a time, start held until busy is low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = apply_frame_op(op, page_number);
        expected_results.push_back(predicted);
        issued++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 27)) begin
          next_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          op <= next_cmd.code;
          page_number <= next_cmd.page;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results are shown for one cycle only
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d page %0d count %0d",
                                status, result_page, ref_count));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (result_page !== want.result_page)
          note_mismatch($sformatf("result_page %0d, want %0d", result_page, want.result_page));
        if (ref_count !== want.ref_count)
          note_mismatch($sformatf("ref_count %0d, want %0d", ref_count, want.ref_count));
        if (copy_needed !== want.copy_needed)
          note_mismatch($sformatf("copy_needed %0b, want %0b", copy_needed, want.copy_needed));
        status_seen[want.status]++;
        if (want.copy_needed) copies++;
      end
    end
  end

  // watchdog on cycles with no activity on any port
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || write_enable) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[page_frame_refcount_allocator_unit] ERROR");
      $finish;
    end
  end

  task automatic push_cmd(input logic [pfra_pkg::OP_W-1:0] code,
                          input logic [pfra_pkg::PAGE_W-1:0] page);
    page_cmd_t c;
    c.code = code;
    c.page = page;
    pending_cmds.push_back(c);
  endtask

  // sampled on the falling edge so the driver's start update has settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [pfra_pkg::REG_W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= val;
    @(posedge clk);
    if (idx == pfra_pkg::REG_TOTAL) cfg_total = val;
    else cfg_first = val;
    write_enable <= 1'b0;
  endtask

  task automatic set_window(input logic [pfra_pkg::REG_W-1:0] total,
                            input logic [pfra_pkg::REG_W-1:0] first);
    wait_drained();
    repeat (4) @(posedge clk);
    write_cfg(pfra_pkg::REG_TOTAL, total);
    write_cfg(pfra_pkg::REG_FIRST, first);
    settings++;
  endtask

  function automatic logic [pfra_pkg::PAGE_W-1:0] pick_page();
    int lo;
    int hi;
    lo = int'(cfg_first) - 2;
    hi = win_end() + 1;
    if (lo < 0) lo = 0;
    if (hi > FRAMES - 1) hi = FRAMES - 1;
    if (lo > hi || $urandom_range(0, 99) < 20)
      return pfra_pkg::PAGE_W'($urandom_range(0, FRAMES - 1));
    return pfra_pkg::PAGE_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic [pfra_pkg::OP_W-1:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return pfra_pkg::OP_ALLOC;
    if (roll < 45) return pfra_pkg::OP_FREE;
    if (roll < 70) return pfra_pkg::OP_SHARE;
    if (roll < 85) return pfra_pkg::OP_RELEASE;
    if (roll < 94) return pfra_pkg::OP_QUERY;
    return OP_UNDEF_FIRST + pfra_pkg::OP_W'($urandom_range(0, 2));
  endfunction

  task automatic queue_random(input int n);
    repeat (n) push_cmd(pick_op(), pick_page());
  endtask

  // drive one frame up to the count ceiling and back down a little
  task automatic queue_saturation();
    push_cmd(pfra_pkg::OP_ALLOC, '0);
    repeat (258) push_cmd(pfra_pkg::OP_SHARE, cfg_first[pfra_pkg::PAGE_W-1:0]);
    push_cmd(pfra_pkg::OP_QUERY, cfg_first[pfra_pkg::PAGE_W-1:0]);
    repeat (3) push_cmd(pfra_pkg::OP_RELEASE, cfg_first[pfra_pkg::PAGE_W-1:0]);
    push_cmd(pfra_pkg::OP_FREE, cfg_first[pfra_pkg::PAGE_W-1:0]);
  endtask

  initial begin
    for (int i = 0; i < FRAMES; i++) frame_refs[i] = '0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // the store is swept to zero after reset
    do @(posedge clk); while (busy);

    // default window: zero counts, then allocate and walk one frame through its counts
    push_cmd(pfra_pkg::OP_QUERY, 12'd1024);
    push_cmd(pfra_pkg::OP_FREE, 12'd1024);
    push_cmd(pfra_pkg::OP_SHARE, 12'd1024);
    push_cmd(pfra_pkg::OP_RELEASE, 12'd1024);
    push_cmd(pfra_pkg::OP_ALLOC, 12'd0);
    push_cmd(pfra_pkg::OP_ALLOC, 12'd4095);
    push_cmd(pfra_pkg::OP_SHARE, 12'd1024);
    push_cmd(pfra_pkg::OP_SHARE, 12'd1024);
    push_cmd(pfra_pkg::OP_RELEASE, 12'd1024);
    push_cmd(pfra_pkg::OP_RELEASE, 12'd1025);
    push_cmd(pfra_pkg::OP_FREE, 12'd1025);
    push_cmd(pfra_pkg::OP_QUERY, 12'd1025);
    push_cmd(pfra_pkg::OP_FREE, 12'd1025);
    push_cmd(pfra_pkg::OP_QUERY, 12'd0);
    push_cmd(pfra_pkg::OP_SHARE, 12'd1023);
    push_cmd(pfra_pkg::OP_RELEASE, 12'd0);
    push_cmd(pfra_pkg::OP_FREE, 12'd4095);
    push_cmd(pfra_pkg::OP_SHARE, 12'd4095);
    push_cmd(OP_UNDEF_FIRST, 12'd1024);
    push_cmd(OP_UNDEF_FIRST + 3'd1, 12'hAAA);
    push_cmd(OP_UNDEF_FIRST + 3'd2, 12'h555);
    push_cmd(pfra_pkg::OP_ALLOC, 12'hFFF);
    push_cmd(pfra_pkg::OP_QUERY, 12'd4095);

    // small window, back to back traffic
    set_window(13'd1040, 13'd1024);
    steady_flow = 1'b1;
    queue_random(300);
    wait_drained();
    steady_flow = 1'b0;

    // upper end past the store, clamped; six frames at the top
    set_window(13'd8191, 13'd4090);
    queue_saturation();
    queue_random(100);

    // empty window
    set_window(13'd0, 13'd0);
    queue_random(40);

    set_window(13'd20, 13'd0);
    queue_random(300);

    // inverted window
    set_window(13'd100, 13'd200);
    queue_random(40);

    set_window(13'd4096, 13'd4096);
    queue_random(30);

    // whole store usable
    set_window(13'd4096, 13'd0);
    queue_random(100);

    set_window(13'd8191, 13'd8191);
    queue_random(20);

    set_window(13'd48, 13'd32);
    queue_random(200);
    // sender holds off until every result is back
    wait_drained();
    queue_random(200);

    set_window(pfra_pkg::RESET_TOTAL, pfra_pkg::RESET_FIRST);
    queue_random(200);

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d transactions over %0d window settings after the default one",
             issued, settings);
    $display("ok %0d, no free %0d, outside %0d, unallocated %0d, saturated %0d, copies %0d",
             status_seen[pfra_pkg::ST_OK], status_seen[pfra_pkg::ST_NOFREE],
             status_seen[pfra_pkg::ST_WINDOW], status_seen[pfra_pkg::ST_NOTALLOC],
             status_seen[pfra_pkg::ST_SAT], copies);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[page_frame_refcount_allocator_unit] OK");
    end else begin
      $display("[page_frame_refcount_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== page_frame_refcount_allocator_unit.f =====
hdl/pfra_pkg.sv
hdl/pfra_ctrl.sv
hdl/pfra_datapath.sv
hdl/page_frame_refcount_allocator_unit.sv
tb/sv/tb.sv
